// File: design/upe_pkg.sv
`timescale 1ns / 1ps

package upe_pkg;

    localparam int CP_W   = 21;
    localparam int COMP_W = 2;
    localparam int CHAR_W = 7;

    typedef enum logic [COMP_W-1:0] {
        COMP_PATH     = 2'd0,
        COMP_QUERY    = 2'd1,
        COMP_FRAGMENT = 2'd2,
        COMP_USERINFO = 2'd3
    } comp_t;

    // position inside one escape triplet
    typedef enum logic [1:0] {
        PH_PCT = 2'd0,
        PH_HI  = 2'd1,
        PH_LO  = 2'd2
    } phase_t;

    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last;
    } upe_char_t;

    localparam logic [CHAR_W-1:0] CH_PCT = 7'h25;

    function automatic logic [CHAR_W-1:0] hex_digit(input logic [3:0] v);
        logic [CHAR_W-1:0] r;
        if (v < 4'd10) begin
            r = 7'h30 + {3'b000, v};
        end else begin
            r = 7'h37 + {3'b000, v};
        end
        return r;
    endfunction

    function automatic logic is_allowed(input logic [CP_W-1:0] cp, input comp_t comp);
        logic [CHAR_W-1:0] c;
        logic              ok;
        c  = cp[CHAR_W-1:0];
        ok = 1'b0;
        if (cp[CP_W-1:CHAR_W] == '0) begin
            if ((c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
                (c >= 7'h61 && c <= 7'h7A)) begin
                ok = 1'b1;
            end
            // unreserved marks and sub-delims
            if (c == 7'h2D || c == 7'h2E || c == 7'h5F || c == 7'h7E ||
                c == 7'h21 || c == 7'h24 || c == 7'h26 || c == 7'h27 ||
                c == 7'h28 || c == 7'h29 || c == 7'h2A || c == 7'h2B ||
                c == 7'h2C || c == 7'h3B || c == 7'h3D) begin
                ok = 1'b1;
            end
            if (comp != COMP_USERINFO && (c == 7'h3A || c == 7'h40 || c == 7'h2F)) begin
                ok = 1'b1;
            end
            if ((comp == COMP_QUERY || comp == COMP_FRAGMENT) && c == 7'h3F) begin
                ok = 1'b1;
            end
        end
        return ok;
    endfunction

endpackage

// File: design/url_percent_encoder.sv
`timescale 1ns / 1ps

// URL percent encoder. Each input beat holds one code point (s_tdata) and
// its URL component (s_tuser: path, query, fragment, user info). A character
// allowed in that component comes out as one beat; any other is sent as its
// UTF-8 bytes, each as '%' and two uppercase hex digits, so 3, 6, 9 or 12
// beats, with m_tlast on the final one. The output stage produces one
// character per cycle while m_tready allows it; the held input register waits
// for its last character. The next input is taken in the cycle its
// predecessor's last character enters the output register, so pass-through
// text streams at one beat per clock while m_tready is high. Surrogates are
// encoded as 3 bytes like other BMP values.
module url_percent_encoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    input  logic [1:0] s_tuser,    // [1:0] component
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [6:0] out_char, [7] zero
    output logic       m_tlast
);
    import upe_pkg::*;

    logic                in_valid_reg;
    logic [CP_W-1:0]     cp_reg;
    comp_t               comp_reg;
    logic [1:0]          byte_idx_reg, byte_idx_next;
    phase_t              phase_reg, phase_next;
    logic                m_valid_reg;
    logic [CHAR_W-1:0]   m_char_reg;
    logic                m_last_reg;

    upe_char_t enc;
    logic      load;
    logic      consume;

    upe_encode u_encode (
        .code_point (cp_reg),
        .component  (comp_reg),
        .byte_idx   (byte_idx_reg),
        .phase      (phase_reg),
        .result     (enc)
    );

    assign load     = in_valid_reg && (!m_valid_reg || m_tready);
    assign consume  = load && enc.last;
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        byte_idx_next = byte_idx_reg;
        phase_next    = phase_reg;
        if (load) begin
            if (enc.last) begin
                byte_idx_next = 2'd0;
                phase_next    = PH_PCT;
            end else begin
                case (phase_reg)
                    PH_PCT:  phase_next = PH_HI;
                    PH_HI:   phase_next = PH_LO;
                    default: begin
                        phase_next    = PH_PCT;
                        byte_idx_next = byte_idx_reg + 2'd1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            byte_idx_reg <= 2'd0;
            phase_reg    <= PH_PCT;
        end else begin
            byte_idx_reg <= byte_idx_next;
            phase_reg    <= phase_next;
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (consume) begin
                in_valid_reg <= 1'b0;
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            cp_reg   <= s_tdata[CP_W-1:0];
            comp_reg <= comp_t'(s_tuser);
        end
        if (load) begin
            m_char_reg <= enc.out_char;
            m_last_reg <= enc.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_char_reg};
    assign m_tlast  = m_last_reg;

endmodule

// File: design/upe_encode.sv
`timescale 1ns / 1ps

module upe_encode (
    input  logic [upe_pkg::CP_W-1:0] code_point,
    input  upe_pkg::comp_t           component,
    input  logic [1:0]               byte_idx,
    input  upe_pkg::phase_t          phase,
    output upe_pkg::upe_char_t       result
);
    import upe_pkg::*;

    logic       pass;
    logic [7:0] bytes [4];
    logic [1:0] last_idx;
    logic [7:0] cur;

    always_comb begin
        bytes[0] = 8'h00;
        bytes[1] = 8'h00;
        bytes[2] = 8'h00;
        bytes[3] = 8'h00;
        if (code_point < 21'h80) begin
            bytes[0] = {1'b0, code_point[6:0]};
            last_idx = 2'd0;
        end else if (code_point < 21'h800) begin
            bytes[0] = {3'b110, code_point[10:6]};
            bytes[1] = {2'b10, code_point[5:0]};
            last_idx = 2'd1;
        end else if (code_point < 21'h10000) begin
            bytes[0] = {4'b1110, code_point[15:12]};
            bytes[1] = {2'b10, code_point[11:6]};
            bytes[2] = {2'b10, code_point[5:0]};
            last_idx = 2'd2;
        end else begin
            // above the Unicode range the plain 4-byte pattern still applies
            bytes[0] = {5'b11110, code_point[20:18]};
            bytes[1] = {2'b10, code_point[17:12]};
            bytes[2] = {2'b10, code_point[11:6]};
            bytes[3] = {2'b10, code_point[5:0]};
            last_idx = 2'd3;
        end
    end

    assign pass = is_allowed(code_point, component);
    assign cur  = bytes[byte_idx];

    always_comb begin
        if (pass) begin
            result.out_char = code_point[CHAR_W-1:0];
            result.last     = 1'b1;
        end else begin
            case (phase)
                PH_PCT:  result.out_char = CH_PCT;
                PH_HI:   result.out_char = hex_digit(cur[7:4]);
                default: result.out_char = hex_digit(cur[3:0]);
            endcase
            result.last = (phase == PH_LO) && (byte_idx == last_idx);
        end
    end

endmodule
